@@ hdl/mlse_pkg.sv @@
// ----------------------------------------------------------------------------
// mlse_pkg: shared types and constants
// Fixed-point formats, item classification, the sequencer state type and the
// exp2 / log2 interpolation tables used by the log-sum-exp likelihood block.
// ----------------------------------------------------------------------------
package mlse_pkg;

  localparam int NUM_CATS_DEF = 32;
  localparam int FRAC_BITS    = 16;
  localparam int VAL_W        = 32;
  localparam int IDX_W        = 5;
  localparam int ACC_W        = 40;
  localparam int TOT_W        = 64;
  localparam int ENTRY_W      = 31;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TERM  = 2'd1;
  localparam logic [1:0] OP_MODEL = 2'd2;
  localparam logic [1:0] OP_LOCUS = 2'd3;

  localparam logic [ACC_W-1:0] Q_ONE   = ACC_W'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0] SUM_MAX = {ACC_W{1'b1}};
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic signed [TOT_W-1:0] PENALTY_Q = -64'sd655360000000000;

  typedef enum logic [1:0] {
    K_WRITE,
    K_TERM,
    K_MODEL,
    K_LOCUS
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic                     idx_ok;
    logic [IDX_W-1:0]         index;
    logic signed [VAL_W-1:0]  value;
    logic                     neg_inf;
    logic                     fin;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TERM_ADD,
    S_MDL_SUM,
    S_MDL_Y,
    S_MDL_INTERP,
    S_MDL_EXP,
    S_MDL_SCALE,
    S_MDL_FOLD,
    S_LOC,
    S_LN_NORM,
    S_LN_MUL,
    S_LN_SUM,
    S_LOC_ADD,
    S_LOC_EMIT
  } state_t;

  function automatic logic signed [ACC_W-1:0] sat40(input logic signed [ACC_W:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[ACC_W] != v[ACC_W-1]) begin
      r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  // 2^-(k/16) in Q30.
  function automatic logic [ENTRY_W-1:0] exp2_tab(input logic [4:0] k);
    logic [ENTRY_W-1:0] r;
    unique case (k)
      5'd0:  r = 31'd1073741824;
      5'd1:  r = 31'd1028218693;
      5'd2:  r = 31'd984625594;
      5'd3:  r = 31'd942880699;
      5'd4:  r = 31'd902905651;
      5'd5:  r = 31'd864625413;
      5'd6:  r = 31'd827968132;
      5'd7:  r = 31'd792864999;
      5'd8:  r = 31'd759250125;
      5'd9:  r = 31'd727060410;
      5'd10: r = 31'd696235444;
      5'd11: r = 31'd666717336;
      5'd12: r = 31'd638450708;
      5'd13: r = 31'd611382493;
      5'd14: r = 31'd585461881;
      5'd15: r = 31'd560640218;
      5'd16: r = 31'd536870912;
      default: r = '0;
    endcase
    return r;
  endfunction

  // log2(1 + k/16) in Q30.
  function automatic logic [ENTRY_W-1:0] log2_tab(input logic [4:0] k);
    logic [ENTRY_W-1:0] r;
    unique case (k)
      5'd0:  r = 31'd0;
      5'd1:  r = 31'd93912511;
      5'd2:  r = 31'd182455581;
      5'd3:  r = 31'd266210140;
      5'd4:  r = 31'd345667660;
      5'd5:  r = 31'd421247625;
      5'd6:  r = 31'd493310944;
      5'd7:  r = 31'd562170370;
      5'd8:  r = 31'd628098702;
      5'd9:  r = 31'd691335320;
      5'd10: r = 31'd752091421;
      5'd11: r = 31'd810554283;
      5'd12: r = 31'd866890747;
      5'd13: r = 31'd921250079;
      5'd14: r = 31'd973766362;
      5'd15: r = 31'd1024560487;
      5'd16: r = 31'd1073741824;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/mlse_if.sv @@
// ----------------------------------------------------------------------------
// mlse_if: stream channels
// Valid/ready channels for the command words and the per-locus result words.
// ----------------------------------------------------------------------------
interface mlse_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             opcode;
  logic [mlse_pkg::IDX_W-1:0]             index;
  logic signed [mlse_pkg::VAL_W-1:0]      value;
  logic                                   prior_neg_inf;
  logic                                   final_locus;

  modport source (output valid, opcode, index, value, prior_neg_inf, final_locus,
                  input ready);
  modport sink (input valid, opcode, index, value, prior_neg_inf, final_locus,
                output ready);
endinterface

interface mlse_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mlse_pkg::TOT_W-1:0]      total;
  logic                                   penalized;
  logic                                   saturated;
  logic                                   last;

  modport source (output valid, total, penalized, saturated, last, input ready);
  modport sink (input valid, total, penalized, saturated, last, output ready);
endinterface

@@ hdl/mixture_log_sum_exp_likelihood.sv @@
// ----------------------------------------------------------------------------
// mixture_log_sum_exp_likelihood: mixture log-likelihood accumulator
// Sums per-model log likelihoods in Q.16, folds them with log-sum-exp per
// locus and keeps a saturating 64-bit running total.
// ----------------------------------------------------------------------------
// Usage: in_ch carries command words (table write, category term, model
// close, locus close); out_ch carries one result word per locus close with
// the running total and its flags. Both are valid/ready channels.
// A two-word queue sits behind in_ch, so the host can keep pushing while the
// sequencer works. In the sequencer, a table write is done once taken, an
// in-range term adds its ratio in a further step, a model close evaluates
// exp and the rescale multiply except for the first finite or an infinite
// prior, and a locus close runs the ln unit, which normalizes the scaled
// sum one bit per cycle, except for an empty or penalized locus.
// A result is registered onto out_ch when its locus close finishes.
// Reset clears the locus state, the total and the queue; the ratio table
// holds garbage until written. When out_ch stalls, the result stays in the
// output register and the sequencer waits at the next locus close only.
// ----------------------------------------------------------------------------
module mixture_log_sum_exp_likelihood #(
  parameter int NUM_CATS = mlse_pkg::NUM_CATS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mlse_in_if.sink     in_ch,
  mlse_out_if.source  out_ch
);

  mlse_pkg::item_t head;
  logic            head_valid;
  logic            pop;

  mlse_front #(
    .NUM_CATS (NUM_CATS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  mlse_back #(
    .NUM_CATS (NUM_CATS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

@@ hdl/mlse_front.sv @@
// ----------------------------------------------------------------------------
// mlse_front: command intake
// Accepts command words, decodes the opcode and category range, and holds
// them in a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module mlse_front #(
  parameter int NUM_CATS = mlse_pkg::NUM_CATS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  mlse_in_if.sink           in_ch,
  output mlse_pkg::item_t   head,
  output logic              head_valid,
  input  logic              pop
);

  mlse_pkg::item_t slots [2];
  mlse_pkg::item_t item;
  logic [1:0]      count;
  logic            wr_ptr;
  logic            rd_ptr;
  logic            push;

  assign in_ch.ready = (count != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign head        = slots[rd_ptr];
  assign head_valid  = (count != 2'd0);

  always_comb begin
    unique case (in_ch.opcode)
      mlse_pkg::OP_WRITE: item.kind = mlse_pkg::K_WRITE;
      mlse_pkg::OP_TERM:  item.kind = mlse_pkg::K_TERM;
      mlse_pkg::OP_MODEL: item.kind = mlse_pkg::K_MODEL;
      default:            item.kind = mlse_pkg::K_LOCUS;
    endcase
    item.idx_ok  = (32'(in_ch.index) < NUM_CATS);
    item.index   = in_ch.index;
    item.value   = in_ch.value;
    item.neg_inf = in_ch.prior_neg_inf;
    item.fin     = in_ch.final_locus;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ hdl/mlse_back.sv @@
// ----------------------------------------------------------------------------
// mlse_back: likelihood sequencer
// Holds the ratio table and the locus state, evaluates exp and ln with
// table interpolation over several steps, and drives the result register.
// ----------------------------------------------------------------------------
module mlse_back #(
  parameter int NUM_CATS = mlse_pkg::NUM_CATS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  mlse_pkg::item_t   head,
  input  logic              head_valid,
  output logic              pop,
  mlse_out_if.source        out_ch
);

  localparam int CatW = (NUM_CATS > 1) ? $clog2(NUM_CATS) : 1;
  localparam int AccW = mlse_pkg::ACC_W;
  localparam int TotW = mlse_pkg::TOT_W;

  mlse_pkg::state_t state, state_next;

  logic signed [31:0]       ratio_mem [NUM_CATS];
  logic signed [31:0]       rd_data;
  mlse_pkg::item_t          cur;

  logic signed [AccW-1:0]   model_sum;
  logic signed [AccW-1:0]   run_max;
  logic [AccW-1:0]          run_sum;
  logic                     finite_seen;
  logic                     models_seen;
  logic signed [TotW-1:0]   total_acc;
  logic                     sat_flag;

  logic signed [AccW-1:0]   lval;
  logic                     up;
  logic                     far;
  logic [21:0]              t_reg;
  logic [22:0]              y_reg;
  logic [30:0]              base;
  logic [38:0]              dprod;
  logic [7:0]               sh;
  logic [16:0]              e_reg;
  logic [40:0]              sc_reg;
  logic [AccW-1:0]          norm;
  logic [5:0]               p;
  logic [60:0]              fprod;
  logic [35:0]              iprod;
  logic signed [TotW-1:0]   addend;
  logic                     pen;

  logic                     out_valid;
  logic signed [TotW-1:0]   out_total;
  logic                     out_pen;
  logic                     out_sat;
  logic                     out_last;
  logic                     out_free;

  // Combinational helpers.
  logic signed [AccW-1:0]   l_calc;
  logic signed [AccW:0]     diff;
  logic [AccW:0]            t_abs;
  logic [52:0]              yprod;
  logic [4:0]               eseg;
  logic [11:0]              erem;
  logic [30:0]              ev;
  logic [4:0]               lseg;
  logic [11:0]              lrem;
  logic [30:0]              lsum;
  logic [36:0]              lnq;
  logic [41:0]              sc_full;
  logic [56:0]              sprod;
  logic signed [TotW:0]     tsum;

  assign out_free       = !out_valid || out_ch.ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.total   = out_total;
  assign out_ch.penalized = out_pen;
  assign out_ch.saturated = out_sat;
  assign out_ch.last    = out_last;

  always_comb begin
    l_calc = mlse_pkg::sat40({model_sum[AccW-1], model_sum}
                             + {{(AccW - 31){cur.value[31]}}, cur.value});
    diff   = {l_calc[AccW-1], l_calc} - {run_max[AccW-1], run_max};
    t_abs  = diff[AccW] ? (AccW + 1)'(0) - diff : diff;
    yprod  = 53'(t_reg) * 53'(mlse_pkg::LOG2E_Q30);
    eseg   = {1'b0, y_reg[15:12]};
    erem   = y_reg[11:0];
    ev     = base - 31'(dprod >> 12);
    lseg   = {1'b0, norm[38:35]};
    lrem   = norm[34:23];
    lsum   = base + 31'(dprod >> 12);
    lnq    = 37'(iprod) + 37'(fprod >> 30);
    sprod  = 57'(run_sum) * 57'(e_reg);
    sc_full = up ? 42'(sc_reg) + 42'(mlse_pkg::Q_ONE) : 42'(sc_reg);
    tsum   = {total_acc[TotW-1], total_acc} + {addend[TotW-1], addend};
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    unique case (state)
      mlse_pkg::S_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          unique case (head.kind)
            mlse_pkg::K_WRITE: state_next = mlse_pkg::S_IDLE;
            mlse_pkg::K_TERM:  state_next = head.idx_ok ? mlse_pkg::S_TERM_ADD
                                                         : mlse_pkg::S_IDLE;
            mlse_pkg::K_MODEL: state_next = mlse_pkg::S_MDL_SUM;
            default:           state_next = mlse_pkg::S_LOC;
          endcase
        end
      end
      mlse_pkg::S_TERM_ADD: state_next = mlse_pkg::S_IDLE;
      mlse_pkg::S_MDL_SUM: begin
        state_next = (cur.neg_inf || !finite_seen) ? mlse_pkg::S_IDLE
                                                   : mlse_pkg::S_MDL_Y;
      end
      mlse_pkg::S_MDL_Y:      state_next = mlse_pkg::S_MDL_INTERP;
      mlse_pkg::S_MDL_INTERP: state_next = mlse_pkg::S_MDL_EXP;
      mlse_pkg::S_MDL_EXP:    state_next = mlse_pkg::S_MDL_SCALE;
      mlse_pkg::S_MDL_SCALE:  state_next = mlse_pkg::S_MDL_FOLD;
      mlse_pkg::S_MDL_FOLD:   state_next = mlse_pkg::S_IDLE;
      mlse_pkg::S_LOC: begin
        state_next = (models_seen && finite_seen) ? mlse_pkg::S_LN_NORM
                                                  : mlse_pkg::S_LOC_ADD;
      end
      mlse_pkg::S_LN_NORM: begin
        if (norm[AccW-1]) begin
          state_next = mlse_pkg::S_LN_MUL;
        end
      end
      mlse_pkg::S_LN_MUL:  state_next = mlse_pkg::S_LN_SUM;
      mlse_pkg::S_LN_SUM:  state_next = mlse_pkg::S_LOC_ADD;
      mlse_pkg::S_LOC_ADD: state_next = mlse_pkg::S_LOC_EMIT;
      mlse_pkg::S_LOC_EMIT: begin
        if (out_free) begin
          state_next = mlse_pkg::S_IDLE;
        end
      end
      default: state_next = mlse_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlse_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Ratio table with a registered read port.
  always_ff @(posedge clk) begin
    if (state == mlse_pkg::S_IDLE && head_valid && head.idx_ok) begin
      if (head.kind == mlse_pkg::K_WRITE) begin
        ratio_mem[CatW'(head.index)] <= head.value;
      end
      rd_data <= ratio_mem[CatW'(head.index)];
    end
  end

  // Datapath registers with no reset.
  always_ff @(posedge clk) begin
    unique case (state)
      mlse_pkg::S_IDLE: begin
        if (head_valid) begin
          cur <= head;
        end
      end
      mlse_pkg::S_MDL_SUM: begin
        lval  <= l_calc;
        up    <= !diff[AccW] && (diff != '0);
        far   <= (t_abs[AccW:22] != '0);
        t_reg <= t_abs[21:0];
      end
      mlse_pkg::S_MDL_Y: y_reg <= yprod[52:30];
      mlse_pkg::S_MDL_INTERP: begin
        base  <= mlse_pkg::exp2_tab(eseg);
        dprod <= 39'(mlse_pkg::exp2_tab(eseg) - mlse_pkg::exp2_tab(eseg + 5'd1))
                 * 39'(erem);
        sh    <= 8'(30 - mlse_pkg::FRAC_BITS) + 8'(y_reg[22:16]);
      end
      mlse_pkg::S_MDL_EXP: begin
        // Shifts of 63 or more, and differences of 64.0 or more, give zero.
        e_reg <= (far || sh >= 8'd63) ? '0 : 17'(ev >> sh[5:0]);
      end
      mlse_pkg::S_MDL_SCALE: begin
        sc_reg <= up ? 41'(sprod >> mlse_pkg::FRAC_BITS)
                     : 41'(run_sum) + 41'(e_reg);
      end
      mlse_pkg::S_LOC: begin
        norm   <= (run_sum < mlse_pkg::Q_ONE) ? mlse_pkg::Q_ONE : run_sum;
        p      <= 6'(AccW - 1);
        addend <= models_seen ? mlse_pkg::PENALTY_Q : '0;
        pen    <= models_seen && !finite_seen;
      end
      mlse_pkg::S_LN_NORM: begin
        if (norm[AccW-1]) begin
          base  <= mlse_pkg::log2_tab(lseg);
          dprod <= 39'(mlse_pkg::log2_tab(lseg + 5'd1) - mlse_pkg::log2_tab(lseg))
                   * 39'(lrem);
        end else begin
          norm <= norm << 1;
          p    <= p - 6'd1;
        end
      end
      mlse_pkg::S_LN_MUL: begin
        fprod <= 61'(lsum) * 61'(mlse_pkg::LN2_Q30);
        iprod <= 36'(p - 6'(mlse_pkg::FRAC_BITS)) * 36'(mlse_pkg::LN2_Q30);
      end
      mlse_pkg::S_LN_SUM: begin
        addend <= TotW'(run_max) + TotW'(lnq >> (30 - mlse_pkg::FRAC_BITS));
        pen    <= 1'b0;
      end
      default: ;
    endcase
  end

  // Locus and total state.
  always_ff @(posedge clk) begin
    if (rst) begin
      model_sum   <= '0;
      run_max     <= '0;
      run_sum     <= '0;
      finite_seen <= 1'b0;
      models_seen <= 1'b0;
      total_acc   <= '0;
      sat_flag    <= 1'b0;
    end else begin
      unique case (state)
        mlse_pkg::S_TERM_ADD: begin
          model_sum <= mlse_pkg::sat40({model_sum[AccW-1], model_sum}
                                       + {{(AccW - 31){rd_data[31]}}, rd_data});
        end
        mlse_pkg::S_MDL_SUM: begin
          models_seen <= 1'b1;
          model_sum   <= '0;
          if (!cur.neg_inf && !finite_seen) begin
            run_max     <= l_calc;
            run_sum     <= mlse_pkg::Q_ONE;
            finite_seen <= 1'b1;
          end
        end
        mlse_pkg::S_MDL_FOLD: begin
          run_sum <= (sc_full > 42'(mlse_pkg::SUM_MAX)) ? mlse_pkg::SUM_MAX
                                                        : AccW'(sc_full);
          if (up) begin
            run_max <= lval;
          end
        end
        mlse_pkg::S_LOC_ADD: begin
          if (tsum[TotW] != tsum[TotW-1]) begin
            total_acc <= tsum[TotW] ? {1'b1, {(TotW-1){1'b0}}}
                                    : {1'b0, {(TotW-1){1'b1}}};
            sat_flag  <= 1'b1;
          end else begin
            total_acc <= tsum[TotW-1:0];
          end
        end
        mlse_pkg::S_LOC_EMIT: begin
          if (out_free) begin
            model_sum   <= '0;
            run_max     <= '0;
            run_sum     <= '0;
            finite_seen <= 1'b0;
            models_seen <= 1'b0;
            if (cur.fin) begin
              total_acc <= '0;
              sat_flag  <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == mlse_pkg::S_LOC_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mlse_pkg::S_LOC_EMIT && out_free) begin
      out_total <= total_acc;
      out_pen   <= pen;
      out_sat   <= sat_flag;
      out_last  <= cur.fin;
    end
  end

endmodule
